@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)
`endif

`endif

@@ design/dcr_pkg.sv @@
// ----------------------------------------------------------------------------
// dcr_pkg
// shared types and constants of the depth color ramp
// ----------------------------------------------------------------------------
package dcr_pkg;

  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 8;
  localparam int T_W     = DEPTH_W + 2;       // 3 * offset
  localparam int PART_W  = DEPTH_W + COLOR_W; // 255 * remainder
  localparam int DIV_BITS = COLOR_W;

  localparam logic [DEPTH_W-1:0] MIN_RANGE_RESET = 16'd500;
  localparam logic [DEPTH_W-1:0] MAX_RANGE_RESET = 16'd5000;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_RANGE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE = 1'b1;

  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 16;

  localparam logic [COLOR_W-1:0] CHAN_OFF  = '0;
  localparam logic [COLOR_W-1:0] CHAN_FULL = '1;

  typedef enum logic [1:0] {
    KIND_BLACK,
    KIND_RED,
    KIND_GREEN,
    KIND_RAMP
  } kind_t;

  typedef enum logic [1:0] {
    SEG_COOL,
    SEG_WARM,
    SEG_HOT
  } seg_t;

  // classified request waiting between front and back
  typedef struct packed {
    kind_t              kind;
    logic [T_W-1:0]     t;
    logic [DEPTH_W-1:0] span;
  } front_item_t;

  // one stage of the back pipeline
  typedef struct packed {
    kind_t              kind;
    seg_t               seg;
    logic [PART_W-1:0]  part;
    logic [DEPTH_W-1:0] span;
    logic [COLOR_W-1:0] quo;
  } div_stage_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

endpackage

@@ design/dcr_fifo.sv @@
// ----------------------------------------------------------------------------
// dcr_fifo
// small register queue with combinational head read
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= wdata;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))

endmodule

@@ design/dcr_front.sv @@
// ----------------------------------------------------------------------------
// dcr_front
// accepts depth samples, sorts them into black, red, green or ramp
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcr_front #(
  parameter int MID_DEPTH = dcr_pkg::MID_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [dcr_pkg::DEPTH_W-1:0]   depth_mm,
  input  logic [dcr_pkg::DEPTH_W-1:0]   min_range_mm,
  input  logic [dcr_pkg::DEPTH_W-1:0]   max_range_mm,
  output dcr_pkg::front_item_t          item,
  output logic                          item_valid,
  input  logic                          item_take
);

  localparam int ITEM_W = $bits(dcr_pkg::front_item_t);

  dcr_pkg::front_item_t          cls;
  logic [dcr_pkg::DEPTH_W-1:0]   offset;
  logic [ITEM_W-1:0]             q_rdata;
  logic                          q_empty;
  logic                          accept;

  assign accept = push && !full;
  assign offset = depth_mm - min_range_mm;

  // green covers both the far end and an empty or reversed range
  always_comb begin
    cls.span = max_range_mm - min_range_mm;
    cls.t    = dcr_pkg::T_W'({offset, 1'b0}) + dcr_pkg::T_W'(offset);
    priority if (depth_mm == '0) begin
      cls.kind = dcr_pkg::KIND_BLACK;
    end else if (depth_mm < min_range_mm) begin
      cls.kind = dcr_pkg::KIND_RED;
    end else if (depth_mm >= max_range_mm) begin
      cls.kind = dcr_pkg::KIND_GREEN;
    end else begin
      cls.kind = dcr_pkg::KIND_RAMP;
    end
  end

  dcr_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(cls),
    .full (full),
    .pop  (item_take),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign item       = dcr_pkg::front_item_t'(q_rdata);
  assign item_valid = !q_empty;

  `ASSERT_IMPLY(a_ramp_inside_span, clk, rst, accept && (cls.kind == dcr_pkg::KIND_RAMP), offset < cls.span)

endmodule

@@ design/dcr_back.sv @@
// ----------------------------------------------------------------------------
// dcr_back
// segment select, pipelined 8-bit divider and color mux into result queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcr_back #(
  parameter int OUT_DEPTH = dcr_pkg::OUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dcr_pkg::front_item_t item,
  input  logic                 item_valid,
  output logic                 item_take,
  output logic                 empty,
  input  logic                 pop,
  output dcr_pkg::pixel_t      pixel
);

  localparam int RES_W  = $clog2(OUT_DEPTH + 1);
  localparam int PIX_W  = $bits(dcr_pkg::pixel_t);
  localparam int DIFF_W = dcr_pkg::T_W + 1;
  localparam int NB     = dcr_pkg::DIV_BITS;

  logic [RES_W-1:0]      reserved;
  logic                  issue;
  logic                  out_full;
  logic                  out_pop;
  logic [PIX_W-1:0]      out_rdata;
  logic [DIFF_W-1:0]     diff1;
  logic [DIFF_W-1:0]     diff2;
  dcr_pkg::div_stage_t   s0_next;
  dcr_pkg::div_stage_t   s0;
  dcr_pkg::div_stage_t   s0_scaled;
  logic                  s0_vld;
  dcr_pkg::div_stage_t   stg     [0:NB];
  logic                  stg_vld [0:NB];
  dcr_pkg::pixel_t       px;
  logic [dcr_pkg::COLOR_W-1:0] val;

  // slots held by the pipeline plus the result queue
  assign issue     = item_valid && (reserved < RES_W'(OUT_DEPTH));
  assign item_take = issue;
  assign out_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved + RES_W'(issue) - RES_W'(out_pop);
    end
  end

  // segment from t against span and twice span
  assign diff1 = {1'b0, item.t} - DIFF_W'(item.span);
  assign diff2 = {1'b0, item.t} - DIFF_W'({item.span, 1'b0});

  always_comb begin
    s0_next.kind = item.kind;
    s0_next.span = item.span;
    s0_next.quo  = '0;
    priority if (!diff2[DIFF_W-1]) begin
      s0_next.seg  = dcr_pkg::SEG_HOT;
      s0_next.part = dcr_pkg::PART_W'(diff2[dcr_pkg::DEPTH_W-1:0]);
    end else if (!diff1[DIFF_W-1]) begin
      s0_next.seg  = dcr_pkg::SEG_WARM;
      s0_next.part = dcr_pkg::PART_W'(diff1[dcr_pkg::DEPTH_W-1:0]);
    end else begin
      s0_next.seg  = dcr_pkg::SEG_COOL;
      s0_next.part = dcr_pkg::PART_W'(item.t[dcr_pkg::DEPTH_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld     <= 1'b0;
      stg_vld[0] <= 1'b0;
    end else begin
      s0_vld     <= issue;
      stg_vld[0] <= s0_vld;
    end
  end

  // dividend is 255 times the remainder
  always_comb begin
    s0_scaled      = s0;
    s0_scaled.part = {s0.part[dcr_pkg::DEPTH_W-1:0], {dcr_pkg::COLOR_W{1'b0}}} - s0.part;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s0 <= s0_next;
    end
    stg[0] <= s0_scaled;
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < NB; j++) begin : g_div
    localparam int BIT = NB - 1 - j;
    logic [dcr_pkg::PART_W:0] cand;
    dcr_pkg::div_stage_t      nxt;

    assign cand = {1'b0, stg[j].part}
                - ((dcr_pkg::PART_W + 1)'(stg[j].span) << BIT);

    always_comb begin
      nxt = stg[j];
      if (!cand[dcr_pkg::PART_W]) begin
        nxt.part     = cand[dcr_pkg::PART_W-1:0];
        nxt.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_vld[j+1] <= 1'b0;
      end else begin
        stg_vld[j+1] <= stg_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      stg[j+1] <= nxt;
    end
  end

  assign val = stg[NB].quo;

  always_comb begin
    px = '{blue: dcr_pkg::CHAN_OFF, green: dcr_pkg::CHAN_OFF, red: dcr_pkg::CHAN_OFF};
    unique case (stg[NB].kind)
      dcr_pkg::KIND_BLACK: ;
      dcr_pkg::KIND_RED:   px.red   = dcr_pkg::CHAN_FULL;
      dcr_pkg::KIND_GREEN: px.green = dcr_pkg::CHAN_FULL;
      dcr_pkg::KIND_RAMP: begin
        unique case (stg[NB].seg)
          dcr_pkg::SEG_COOL: begin
            px.blue  = val;
            px.green = val;
            px.red   = ~val;
          end
          dcr_pkg::SEG_WARM: begin
            px.blue  = dcr_pkg::CHAN_FULL;
            px.green = ~val;
          end
          default: begin
            px.blue  = ~val;
            px.green = val;
          end
        endcase
      end
      default: ;
    endcase
  end

  dcr_fifo #(
    .WIDTH(PIX_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (stg_vld[NB]),
    .wdata(px),
    .full (out_full),
    .pop  (pop),
    .rdata(out_rdata),
    .empty(empty)
  );

  assign pixel = dcr_pkg::pixel_t'(out_rdata);

  `ASSERT_IMPLY(a_room_on_arrival, clk, rst, stg_vld[NB], !out_full)
  `ASSERT_ALWAYS(a_reserve_bound, clk, rst, reserved <= RES_W'(OUT_DEPTH))
  `ASSERT_NEXT(a_issue_enters, clk, rst, issue, s0_vld)

endmodule

@@ design/depth_color_ramp.sv @@
// ----------------------------------------------------------------------------
// depth_color_ramp
// depth sample in millimetres to blue, green, red pixel
// ----------------------------------------------------------------------------
// Takes one depth sample per clock and gives one pixel per sample, in order.
// A zero depth is black, a depth below min_range_mm is red, a depth at or
// past max_range_mm (or any nonzero depth at or past min when the range is
// empty or reversed) is green. In between, the range is cut into three equal
// segments, each a 0..255 ramp: red to cyan, then to blue, then to green.
// Throughput is one sample per cycle as long as pop keeps up. A sample
// passes through the classifier queue, a segment select register, a register
// that forms 255 times the remainder, then eight stages of a restoring
// divider that yields one color bit per stage. The result queue holds
// OUT_DEPTH pixels; the back end only starts a sample when a result slot is
// reserved for it, so a stalled pop fills the result queue, then the
// classifier queue (MID_DEPTH), then raises full. Configuration is written
// through cfg_we, cfg_index (0 = min range, 1 = max range) and cfg_data;
// the user must do so only while no sample is in flight; no check enforces it.
// ----------------------------------------------------------------------------
module depth_color_ramp #(
  parameter int MID_DEPTH = dcr_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = dcr_pkg::OUT_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // depth request side
  input  logic                            push,
  output logic                            full,
  input  logic [dcr_pkg::DEPTH_W-1:0]     depth_mm,
  // pixel request side
  output logic                            empty,
  input  logic                            pop,
  output logic [dcr_pkg::COLOR_W-1:0]     blue,
  output logic [dcr_pkg::COLOR_W-1:0]     green,
  output logic [dcr_pkg::COLOR_W-1:0]     red,
  // register write port
  input  logic                            cfg_we,
  input  logic [dcr_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [dcr_pkg::DEPTH_W-1:0]     cfg_data
);

  logic [dcr_pkg::DEPTH_W-1:0] min_range_mm;
  logic [dcr_pkg::DEPTH_W-1:0] max_range_mm;
  dcr_pkg::front_item_t        item;
  logic                        item_valid;
  logic                        item_take;
  dcr_pkg::pixel_t             pixel;

  // ramp end registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_range_mm <= dcr_pkg::MIN_RANGE_RESET;
      max_range_mm <= dcr_pkg::MAX_RANGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcr_pkg::REG_MIN_RANGE: min_range_mm <= cfg_data;
        dcr_pkg::REG_MAX_RANGE: max_range_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify and queue
  dcr_front #(
    .MID_DEPTH(MID_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .depth_mm    (depth_mm),
    .min_range_mm(min_range_mm),
    .max_range_mm(max_range_mm),
    .item        (item),
    .item_valid  (item_valid),
    .item_take   (item_take)
  );

  // divide, color and hold results
  dcr_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .item_valid(item_valid),
    .item_take (item_take),
    .empty     (empty),
    .pop       (pop),
    .pixel     (pixel)
  );

  assign blue  = pixel.blue;
  assign green = pixel.green;
  assign red   = pixel.red;

endmodule
